// ===== rtl/bpt_pkg.sv =====
`timescale 1ns / 1ps

package bpt_pkg;

   // Item kinds carried on req_tuser.
   localparam logic [1:0] KIND_QUERY   = 2'd0;
   localparam logic [1:0] KIND_FAIL    = 2'd1;
   localparam logic [1:0] KIND_SUCCESS = 2'd2;

   // Configuration register indexes.
   localparam logic CSR_BASE_DELAY = 1'b0;
   localparam logic CSR_MAX_DELAY  = 1'b1;

   localparam logic [15:0] BASE_DELAY_RESET = 16'd30;
   localparam logic [15:0] MAX_DELAY_RESET  = 16'd3600;

   // Token that walks down the row of cells, one cell per cycle while the row is not stalled.
   typedef struct packed {
      logic        valid;
      logic [1:0]  kind;
      logic [31:0] addr;
      logic [31:0] now;
      logic        done;
      logic        hit;
      logic        blocked;
      logic [15:0] delay;
      logic        stored;
   } tok_type;

   // Penalty for a given failure count: min(base << (count-1), max).
   // The caller passes shift = count-1 split into its low four bits and a
   // flag that is set when the shift is sixteen or more.
   function automatic logic [15:0] penalty(input logic [15:0] base,
                                           input logic [15:0] max_d,
                                           input logic [3:0]  shift,
                                           input logic        big);
      logic [30:0] d;
      d = {15'd0, base} << shift;
      if (base == 16'd0) begin
         penalty = 16'd0;
      end else if (big) begin
         penalty = max_d;
      end else if (d > {15'd0, max_d}) begin
         penalty = max_d;
      end else begin
         penalty = d[15:0];
      end
   endfunction

endpackage

// ===== rtl/bpt_cell.sv =====
`timescale 1ns / 1ps

// One table entry. The token from the previous cell is examined, the entry
// is updated when the token claims it, and the token moves on registered.
module bpt_cell #(
   parameter int FAIL_COUNT_BITS = 8
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              adv,
   input  logic [15:0]       base_delay,
   input  logic [15:0]       max_delay,
   input  bpt_pkg::tok_type  tok_i,
   output bpt_pkg::tok_type  tok_o
);

   localparam logic [FAIL_COUNT_BITS-1:0] FailMax = '1;

   logic                        used_ff;
   logic [31:0]                 addr_ff;
   logic [32:0]                 until_ff;
   logic [FAIL_COUNT_BITS-1:0]  fails_ff;
   bpt_pkg::tok_type            tok_ff;

   bpt_pkg::tok_type            tok_in;
   logic                        write_fail;
   logic                        write_clear;
   logic                        match;
   logic                        claim;
   logic [FAIL_COUNT_BITS-1:0]  cnt_old;
   logic [FAIL_COUNT_BITS-1:0]  cnt_new;
   logic [FAIL_COUNT_BITS-1:0]  shift;
   logic                        big;
   logic [15:0]                 pen;
   logic [32:0]                 until_new;

   // Lookup against this entry; only the first match along the row claims.
   assign match = used_ff && (addr_ff == tok_i.addr);
   assign claim = tok_i.valid && !tok_i.done;

   // Saturating count and the penalty that follows from it.
   assign cnt_old   = match ? fails_ff : '0;
   assign cnt_new   = (cnt_old == FailMax) ? FailMax : cnt_old + 1'b1;
   assign shift     = cnt_new - 1'b1;
   assign big       = shift > FAIL_COUNT_BITS'(15);
   assign pen       = bpt_pkg::penalty(base_delay, max_delay, shift[3:0], big);
   assign until_new = {1'b0, tok_i.now} + {17'd0, pen};

   always_comb begin
      tok_in      = tok_i;
      write_fail  = 1'b0;
      write_clear = 1'b0;
      unique case (tok_i.kind)
         bpt_pkg::KIND_QUERY: begin
            if (claim && match) begin
               tok_in.done    = 1'b1;
               tok_in.hit     = 1'b1;
               tok_in.blocked = {1'b0, tok_i.now} < until_ff;
            end
         end
         bpt_pkg::KIND_FAIL: begin
            // An unused cell follows all used ones, so it is the append slot.
            if (claim && (match || !used_ff)) begin
               tok_in.done   = 1'b1;
               tok_in.hit    = match;
               tok_in.delay  = pen;
               tok_in.stored = 1'b1;
               write_fail    = 1'b1;
            end
         end
         bpt_pkg::KIND_SUCCESS: begin
            if (claim && match) begin
               tok_in.done = 1'b1;
               tok_in.hit  = 1'b1;
               write_clear = fails_ff != '0;
            end
         end
         default: begin
            tok_in = tok_i;
         end
      endcase
   end

   // Entry state; only the used flag needs a reset.
   always_ff @(posedge clock) begin
      if (reset) begin
         used_ff <= 1'b0;
      end else if (adv && write_fail) begin
         used_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (adv && write_fail) begin
         addr_ff  <= tok_i.addr;
         fails_ff <= cnt_new;
         until_ff <= until_new;
      end else if (adv && write_clear) begin
         fails_ff <= '0;
         until_ff <= '0;
      end
   end

   // Token hand-off to the next cell.
   always_ff @(posedge clock) begin
      if (reset) begin
         tok_ff.valid <= 1'b0;
      end else if (adv) begin
         tok_ff <= tok_in;
      end
   end

   assign tok_o = tok_ff;

endmodule

// ===== rtl/backoff_penalty_table.sv =====
`timescale 1ns / 1ps

// The accepted item is registered in the entry register, then its token crosses
// the table cells one cell per cycle while the row is not stalled, and the result
// is registered in the output register. One item is in flight at a time; a new
// item is taken while the previous result still waits in the output register.
// Reset: synchronous, active high; empties the table and loads base 30 s, cap 3600 s.
module backoff_penalty_table #(
   parameter int TABLE_ENTRIES   = 16,
   parameter int FAIL_COUNT_BITS = 8
) (
   input  logic        clock,
   input  logic        reset,
   // Request item.
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [63:0] req_tdata,   // [31:0] peer_addr, [63:32] now_sec
   input  logic [1:0]  req_tuser,   // [1:0] kind
   // Result item.
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,   // [0] hit, [1] blocked, [17:2] applied_delay,
                                    // [18] stored, [23:19] zero
   // Configuration writes.
   input  logic        csr_we,
   input  logic        csr_addr,
   input  logic [15:0] csr_wdata
);

   logic              busy_ff;
   logic              busy_in;
   logic [15:0]       base_ff;
   logic [15:0]       max_ff;
   bpt_pkg::tok_type  src_ff;
   logic              rsp_valid_ff;
   logic [18:0]       rsp_data_ff;
   logic              accept;
   logic              adv;
   bpt_pkg::tok_type  tok [TABLE_ENTRIES+1];

   assign accept     = req_tvalid && req_tready;
   assign req_tready = !busy_ff;

   // The row stalls only when a finished token meets a full output register.
   assign adv = !(tok[TABLE_ENTRIES].valid && rsp_valid_ff && !rsp_tready);

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         base_ff <= bpt_pkg::BASE_DELAY_RESET;
         max_ff  <= bpt_pkg::MAX_DELAY_RESET;
      end else if (csr_we) begin
         unique case (csr_addr)
            bpt_pkg::CSR_BASE_DELAY: base_ff <= csr_wdata;
            bpt_pkg::CSR_MAX_DELAY:  max_ff  <= csr_wdata;
            default:                 base_ff <= base_ff;
         endcase
      end
   end

   // One item in flight at a time.
   always_comb begin
      busy_in = busy_ff;
      if (accept) begin
         busy_in = 1'b1;
      end else if (tok[TABLE_ENTRIES].valid && adv) begin
         busy_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
      end
   end

   // Entry register that feeds the first cell.
   always_ff @(posedge clock) begin
      if (reset) begin
         src_ff.valid <= 1'b0;
      end else if (accept) begin
         src_ff.valid   <= 1'b1;
         src_ff.kind    <= req_tuser;
         src_ff.addr    <= req_tdata[31:0];
         src_ff.now     <= req_tdata[63:32];
         src_ff.done    <= 1'b0;
         src_ff.hit     <= 1'b0;
         src_ff.blocked <= 1'b0;
         src_ff.delay   <= 16'd0;
         src_ff.stored  <= 1'b0;
      end else if (adv) begin
         src_ff.valid <= 1'b0;
      end
   end

   assign tok[0] = src_ff;

   // Row of table cells.
   for (genvar i = 0; i < TABLE_ENTRIES; i++) begin : g_cell
      bpt_cell #(
         .FAIL_COUNT_BITS (FAIL_COUNT_BITS)
      ) u_cell (
         .clock      (clock),
         .reset      (reset),
         .adv        (adv),
         .base_delay (base_ff),
         .max_delay  (max_ff),
         .tok_i      (tok[i]),
         .tok_o      (tok[i+1])
      );
   end

   // Output register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (tok[TABLE_ENTRIES].valid && adv) begin
         rsp_valid_ff <= 1'b1;
         rsp_data_ff  <= {tok[TABLE_ENTRIES].stored, tok[TABLE_ENTRIES].delay,
                          tok[TABLE_ENTRIES].blocked, tok[TABLE_ENTRIES].hit};
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {5'd0, rsp_data_ff};

endmodule
